// File: rtl/lspc_pkg.sv
// Shared types, constants and functions for the line sensor position classifier.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lspc_pkg;

    localparam int SENSOR_COUNT = 7;
    localparam int CNT_W        = 3;
    localparam int POS_W        = 8;
    localparam int WEIGHT_W     = 8;
    localparam int SUM_W        = 11;  // 7 * 8-bit signed weights
    localparam int DVD_W        = 10;  // magnitude of the sum
    localparam int DIV_STEPS    = DVD_W / 2;  // two quotient bits per step
    localparam int STEP_W       = $clog2(DIV_STEPS);
    localparam int REG_IDX_W    = 3;
    localparam int PADDR_W      = REG_IDX_W + 2;
    localparam int PDATA_W      = 32;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_INVERT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT0 = 3'd1;

    // Line state codes
    localparam logic [2:0] LS_ON_LINE     = 3'd0;
    localparam logic [2:0] LS_LEFT        = 3'd1;
    localparam logic [2:0] LS_RIGHT       = 3'd2;
    localparam logic [2:0] LS_SHARP_LEFT  = 3'd3;
    localparam logic [2:0] LS_SHARP_RIGHT = 3'd4;
    localparam logic [2:0] LS_NONE        = 3'd5;
    localparam logic [2:0] LS_ALL         = 3'd6;

    localparam logic signed [POS_W-1:0] POS_LOW_LIMIT  = -8'sd15;
    localparam logic signed [POS_W-1:0] POS_HIGH_LIMIT = 8'sd15;

    // Reset weights, sensor 6 in the top byte
    localparam logic [SENSOR_COUNT-1:0][WEIGHT_W-1:0] WEIGHT_RESET =
        {8'd30, 8'd20, 8'd10, 8'd0, 8'hF6, 8'hEC, 8'hE2};

    typedef struct packed {
        logic                                  invert;
        logic [SENSOR_COUNT-1:0][WEIGHT_W-1:0] weight;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // Empty and full bitmaps first, then the pattern table, then the position threshold
    function automatic logic [2:0] classify(
        input logic [SENSOR_COUNT-1:0]       bits,
        input logic [CNT_W-1:0]              count,
        input logic signed [POS_W-1:0]       pos
    );
        logic [2:0] st;
        if (count == '0) begin
            st = LS_NONE;
        end
        else if (count == CNT_W'(SENSOR_COUNT)) begin
            st = LS_ALL;
        end
        else begin
            case (bits)
                7'h08, 7'h18, 7'h0C, 7'h1C:        st = LS_ON_LINE;
                7'h01, 7'h03, 7'h07, 7'h30, 7'h38: st = LS_LEFT;
                7'h40, 7'h60, 7'h70, 7'h06, 7'h0E: st = LS_RIGHT;
                7'h02, 7'h04:                      st = LS_SHARP_LEFT;
                7'h20, 7'h10:                      st = LS_SHARP_RIGHT;
                default:
                begin
                    if (pos < POS_LOW_LIMIT) begin
                        st = LS_LEFT;
                    end
                    else if (pos > POS_HIGH_LIMIT) begin
                        st = LS_RIGHT;
                    end
                    else begin
                        st = LS_ON_LINE;
                    end
                end
            endcase
        end
        return st;
    endfunction

endpackage

// File: rtl/lspc_in_if.sv
// Input channel of the line sensor position classifier: one raw pin sample.
// Depends on lspc_pkg.
`timescale 1ns / 1ps

interface lspc_in_if
    import lspc_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [SENSOR_COUNT-1:0] raw_pins;

    modport source (output valid, output raw_pins, input ready);
    modport sink   (input valid, input raw_pins, output ready);
endinterface

// File: rtl/lspc_out_if.sv
// Output channel of the line sensor position classifier: one classified item.
// Depends on lspc_pkg.
`timescale 1ns / 1ps

interface lspc_out_if
    import lspc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [SENSOR_COUNT-1:0]    sensor_bits;
    logic [CNT_W-1:0]           active_count;
    logic signed [POS_W-1:0]    position;
    logic [2:0]                 line_state;
    logic                       line_seen;

    modport source (output valid, output sensor_bits, output active_count,
                    output position, output line_state, output line_seen,
                    input ready);
    modport sink   (input valid, input sensor_bits, input active_count,
                    input position, input line_state, input line_seen,
                    output ready);
endinterface

// File: rtl/lspc_regs.sv
// APB-style configuration registers: inversion flag and seven sensor weights.
// Depends on lspc_pkg.
`timescale 1ns / 1ps

module lspc_regs
    import lspc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic                                  invert_reg;
    logic [SENSOR_COUNT-1:0][WEIGHT_W-1:0] weight_reg;
    logic [REG_IDX_W-1:0]                  idx;
    logic [REG_IDX_W-1:0]                  widx;
    logic                                  wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_W-1:2];
    assign widx   = idx - REG_WEIGHT0;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            invert_reg <= 1'b0;
            weight_reg <= WEIGHT_RESET;
        end
        else if (wr_en) begin
            case (idx)
                REG_INVERT: invert_reg <= pwdata[0];
                default:    weight_reg[widx] <= pwdata[WEIGHT_W-1:0];
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (idx)
            REG_INVERT: prdata = {{(PDATA_W-1){1'b0}}, invert_reg};
            default:    prdata = {{(PDATA_W-WEIGHT_W){1'b0}}, weight_reg[widx]};
        endcase
    end

    assign cfg.invert = invert_reg;
    assign cfg.weight = weight_reg;

endmodule

// File: rtl/lspc_dp.sv
// Datapath: active bitmap, weighted sum, two-bit-per-step divider, output register.
// Depends on lspc_pkg; driven by lspc_ctrl through cmd_t.
`timescale 1ns / 1ps

module lspc_dp
    import lspc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic [SENSOR_COUNT-1:0] raw_pins,
    lspc_out_if.source              out_ch
);

    logic [SENSOR_COUNT-1:0]    bits_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       neg_reg;
    logic [DVD_W-1:0]           dvd_reg;
    logic [2:0]                 rem_reg;
    logic [DVD_W-1:0]           quo_reg;
    logic signed [POS_W-1:0]    held_reg;

    logic                       out_valid_reg;
    logic [SENSOR_COUNT-1:0]    out_bits_reg;
    logic [CNT_W-1:0]           out_count_reg;
    logic signed [POS_W-1:0]    out_pos_reg;
    logic [2:0]                 out_state_reg;

    logic signed [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]           cnt;
    logic [SUM_W-1:0]           mag;
    logic [3:0]                 div_c;
    logic [3:0]                 r1;
    logic [3:0]                 r1s;
    logic                       q1;
    logic [3:0]                 r2;
    logic [3:0]                 r2s;
    logic                       q0;
    logic [POS_W-1:0]           mean;
    logic signed [POS_W-1:0]    pos_next;

    // Sum the weights of the active sensors and count them
    always_comb
    begin
        sum = '0;
        cnt = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (bits_reg[i]) begin
                sum = sum + {{(SUM_W-WEIGHT_W){cfg.weight[i][WEIGHT_W-1]}}, cfg.weight[i]};
                cnt = cnt + 3'd1;
            end
        end
        mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    end

    // Two restoring divide steps per cycle
    assign div_c = {1'b0, count_reg};
    assign r1    = {rem_reg, dvd_reg[DVD_W-1]};
    assign q1    = (r1 >= div_c);
    assign r1s   = q1 ? r1 - div_c : r1;
    assign r2    = {r1s[2:0], dvd_reg[DVD_W-2]};
    assign q0    = (r2 >= div_c);
    assign r2s   = q0 ? r2 - div_c : r2;

    // Truncate toward zero: divide magnitudes, then restore the sign
    assign mean     = neg_reg ? POS_W'(-quo_reg[POS_W-1:0]) : quo_reg[POS_W-1:0];
    assign pos_next = (count_reg != '0) ? signed'(mean) : held_reg;

    // Hold the working registers of the item in flight
    always_ff @(posedge clk)
    begin
        if (cmd.load_in) begin
            bits_reg <= cfg.invert ? raw_pins : ~raw_pins;
        end
        if (cmd.prep) begin
            count_reg <= cnt;
            neg_reg   <= sum[SUM_W-1];
            dvd_reg   <= mag[DVD_W-1:0];
            rem_reg   <= '0;
            quo_reg   <= '0;
        end
        else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[DVD_W-3:0], 2'b00};
            rem_reg <= r2s[2:0];
            quo_reg <= {quo_reg[DVD_W-3:0], q1, q0};
        end
    end

    // Keep the last position across items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg <= '0;
        end
        else if (cmd.commit) begin
            held_reg <= pos_next;
        end
    end

    // Advance the output register: fill on commit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit) begin
            out_bits_reg  <= bits_reg;
            out_count_reg <= count_reg;
            out_pos_reg   <= pos_next;
            out_state_reg <= classify(bits_reg, count_reg, pos_next);
        end
    end

    assign status.out_free     = !out_valid_reg || out_ch.ready;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.sensor_bits  = out_bits_reg;
    assign out_ch.active_count = out_count_reg;
    assign out_ch.position     = out_pos_reg;
    assign out_ch.line_state   = out_state_reg;
    assign out_ch.line_seen    = (out_count_reg != '0);

endmodule

// File: rtl/lspc_ctrl.sv
// Controller: sequences accept, sum, divide steps and commit for one item.
// Depends on lspc_pkg; drives lspc_dp through cmd_t.
`timescale 1ns / 1ps

module lspc_ctrl
    import lspc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

`ifndef SYNTHESIS
    // An accepted item always moves on to the sum stage
    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_PREP))
        else $error("accepted item did not enter the sum stage");

    // Divider step count never runs past the last step
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (step_reg <= STEP_W'(DIV_STEPS - 1)))
        else $error("divider step count out of range");

    // A finished item waits while the output register is full
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !status.out_free) |=> (state_reg == ST_DONE))
        else $error("item left the commit stage with the output full");

    // Commands never overlap
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_in, cmd.prep, cmd.div_step, cmd.commit}))
        else $error("overlapping datapath commands");
`endif

endmodule

// File: rtl/line_sensor_position_classifier_core.sv
// Top level of the seven-sensor line position classifier.
// Depends on lspc_pkg, lspc_in_if, lspc_out_if, lspc_regs, lspc_ctrl, lspc_dp.
//
//  channel   direction  payload                                         handshake
//  in_ch     in         raw_pins[6:0]                                   valid/ready
//  out_ch    out        sensor_bits, active_count, position,            valid/ready
//                       line_state, line_seen
//  apb       in         psel/penable/pwrite, paddr[4:0], pwdata/prdata  pready = 1
//
// An item passes through accept, weighted sum, five two-bit divide steps
// and commit; a new item is accepted only once the last one has committed.
// A result waits in the output register while the next item is worked on;
// commit stalls only while that register is still full.
// rst_n is asynchronous, active low; it restores default weights and a zero position.
`timescale 1ns / 1ps

module line_sensor_position_classifier_core
    import lspc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    lspc_in_if.sink            in_ch,
    lspc_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    lspc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lspc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lspc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .raw_pins (in_ch.raw_pins),
        .out_ch   (out_ch)
    );

endmodule
